// ===== design/sincos_pkg.sv =====
package sincos_pkg;

    // cordic step count and rail run limit
    localparam int CordicSteps = 16;
    localparam int RailHits    = 100;

    // configuration register indexes
    localparam logic [2:0] RegSinLowCap  = 3'd0;
    localparam logic [2:0] RegSinHighCap = 3'd1;
    localparam logic [2:0] RegCosLowCap  = 3'd2;
    localparam logic [2:0] RegCosHighCap = 3'd3;
    localparam logic [2:0] RegSpanNeeded = 3'd4;
    localparam logic [2:0] RegAmpFloor   = 3'd5;
    localparam logic [2:0] RegAmpLowLim  = 3'd6;
    localparam logic [2:0] RegRailMargin = 3'd7;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'h20000000;
            5'd1:  atan_turn = 32'h12E4051E;
            5'd2:  atan_turn = 32'h09FB385B;
            5'd3:  atan_turn = 32'h051111D4;
            5'd4:  atan_turn = 32'h028B0D43;
            5'd5:  atan_turn = 32'h0145D7E1;
            5'd6:  atan_turn = 32'h00A2F61E;
            5'd7:  atan_turn = 32'h00517C55;
            5'd8:  atan_turn = 32'h0028BE53;
            5'd9:  atan_turn = 32'h00145F2F;
            5'd10: atan_turn = 32'h000A2F98;
            5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6;
            5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2FA;
            5'd15: atan_turn = 32'h0000517D;
            5'd16: atan_turn = 32'h000028BE;
            5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A30;
            5'd19: atan_turn = 32'h00000518;
            5'd20: atan_turn = 32'h0000028C;
            5'd21: atan_turn = 32'h00000146;
            5'd22: atan_turn = 32'h000000A3;
            5'd23: atan_turn = 32'h00000051;
            default: atan_turn = 32'h0;
        endcase
    endfunction

endpackage

// ===== design/sincos_encoder_angle_tracker.sv =====
// Sine/cosine encoder angle tracker. Each input word is either a sample pair
// or a bounds-reset command and gives exactly one result word. A pair widens
// the tracked min/max of both channels, turns the centered pair into an angle
// in 1/65536 turn through a shift-add CORDIC, keeps an exponential average of
// the magnitude and counts low-amplitude and at-rail runs into fault pulses.
// A small sequencer reuses one 18x18 multiplier, one CORDIC adder/shifter and
// one square-root step. From acceptance a pair passes through a bounds state,
// the multiplier states (the two CORDIC inputs and the two squares), a
// pre-rotation state, 16 CORDIC steps, a setup state, 26 square-root steps,
// an average state and a run-count state before its result is valid. When
// the quality checks are not active the root and average are skipped. A
// reset command's result is valid the cycle after acceptance. A stalled
// result holds the block. The block takes no new word until the result has
// been handed over. Configuration is written through the cfg port while the
// block is idle.
module sincos_encoder_angle_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_sin_sample,
    input  logic [15:0] s_cos_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_angle,
    output logic        m_angle_valid,
    output logic        m_quality_active,
    output logic [24:0] m_magnitude_avg,
    output logic        m_amp_fault,
    output logic        m_rail_fault
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_BOUNDS, ST_MUL, ST_ROT, ST_CORDIC, ST_SQSUM, ST_SQRT,
        ST_AVG, ST_RUNS, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] sin_lo_cap_reg, sin_hi_cap_reg, cos_lo_cap_reg, cos_hi_cap_reg;
    logic [15:0] span_needed_reg, amp_floor_reg, amp_low_limit_reg;
    logic [14:0] rail_margin_reg;

    // tracking state
    logic [15:0] sin_lo_reg, sin_hi_reg, cos_lo_reg, cos_hi_reg;
    logic [24:0] avg_reg;
    logic        started_reg;
    logic [15:0] low_run_reg, rail_run_reg;

    // item working registers
    logic [15:0] rs_reg, rc_reg, cs_reg, cc_reg;
    logic signed [17:0] ds_reg, dc_reg;
    logic [16:0] sspan_reg, cspan_reg;
    logic        valid_reg, active_reg;
    logic signed [37:0] x_reg, y_reg;
    logic [31:0] phase_reg;
    logic [4:0]  step_reg;
    logic [1:0]  mcnt_reg;
    logic [51:0] rem_reg, root_reg;
    logic [35:0] sq_reg;
    logic [24:0] mag_reg;

    // result
    logic [15:0] o_angle_reg;
    logic        o_aval_reg, o_act_reg, o_af_reg, o_rf_reg;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_angle          = o_angle_reg;
    assign m_angle_valid    = o_aval_reg;
    assign m_quality_active = o_act_reg;
    assign m_magnitude_avg  = avg_reg & {25{o_act_reg | started_reg}};
    assign m_amp_fault      = o_af_reg;
    assign m_rail_fault     = o_rf_reg;

    // clamp of the incoming pair
    logic [15:0] cs_c, cc_c;
    always_comb begin
        cs_c = (s_sin_sample < sin_lo_cap_reg) ? sin_lo_cap_reg : s_sin_sample;
        if (cs_c > sin_hi_cap_reg) cs_c = sin_hi_cap_reg;
        cc_c = (s_cos_sample < cos_lo_cap_reg) ? cos_lo_cap_reg : s_cos_sample;
        if (cc_c > cos_hi_cap_reg) cc_c = cos_hi_cap_reg;
    end

    // cordic step, shifts floor on signed values
    logic signed [37:0] xs_c, ys_c;
    assign xs_c = x_reg >>> step_reg;
    assign ys_c = y_reg >>> step_reg;

    // square-root step: bit = 4^step
    logic [51:0] bit_c, trial_c;
    assign bit_c   = 52'd1 << {step_reg, 1'b0};
    assign trial_c = root_reg + bit_c;

    // centered raw values for the magnitude
    logic signed [17:0] a_c, b_c;
    assign a_c = $signed({1'b0, rs_reg, 1'b0})
               - $signed({1'b0, {1'b0, sin_lo_reg} + {1'b0, sin_hi_reg}});
    assign b_c = $signed({1'b0, rc_reg, 1'b0})
               - $signed({1'b0, {1'b0, cos_lo_reg} + {1'b0, cos_hi_reg}});

    // shared 18x18 signed multiplier, operands chosen by phase
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    always_comb begin
        case (mcnt_reg)
            2'd0: begin mul_a = dc_reg; mul_b = $signed({1'b0, sspan_reg}); end
            2'd1: begin mul_a = ds_reg; mul_b = $signed({1'b0, cspan_reg}); end
            2'd2: begin mul_a = a_c;    mul_b = a_c; end
            default: begin mul_a = b_c; mul_b = b_c; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // average update
    logic signed [26:0] delta_c;
    logic signed [43:0] dprod_c;
    logic signed [27:0] dstep_c;
    assign delta_c = $signed({2'b0, mag_reg}) - $signed({2'b0, avg_reg});
    assign dprod_c = delta_c * $signed(17'sd3277) + 44'sd32768;
    assign dstep_c = dprod_c[43:16];

    // rail check on raw samples
    logic at_rail_c;
    always_comb begin
        at_rail_c = ({1'b0, rs_reg} < {1'b0, sin_lo_cap_reg} + {2'b0, rail_margin_reg})
            || ($signed({2'b0, rs_reg}) > $signed({2'b0, sin_hi_cap_reg}) - $signed({3'b0, rail_margin_reg}))
            || ({1'b0, rc_reg} < {1'b0, cos_lo_cap_reg} + {2'b0, rail_margin_reg})
            || ($signed({2'b0, rc_reg}) > $signed({2'b0, cos_hi_cap_reg}) - $signed({3'b0, rail_margin_reg}));
    end

    logic [15:0] low_inc_c, rail_inc_c;
    assign low_inc_c  = low_run_reg + 16'd1;
    assign rail_inc_c = rail_run_reg + 16'd1;

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sin_lo_cap_reg <= 16'd0;     sin_hi_cap_reg <= 16'hFFFF;
            cos_lo_cap_reg <= 16'd0;     cos_hi_cap_reg <= 16'hFFFF;
            span_needed_reg <= 16'd1000; amp_floor_reg <= 16'd500;
            amp_low_limit_reg <= 16'd100; rail_margin_reg <= 15'd64;
            sin_lo_reg <= 16'hFFFF; sin_hi_reg <= 16'd0;
            cos_lo_reg <= 16'hFFFF; cos_hi_reg <= 16'd0;
            avg_reg <= '0; started_reg <= 1'b0;
            low_run_reg <= '0; rail_run_reg <= '0;
            o_act_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        case (cfg_index)
                            sincos_pkg::RegSinLowCap:  sin_lo_cap_reg <= cfg_data;
                            sincos_pkg::RegSinHighCap: sin_hi_cap_reg <= cfg_data;
                            sincos_pkg::RegCosLowCap:  cos_lo_cap_reg <= cfg_data;
                            sincos_pkg::RegCosHighCap: cos_hi_cap_reg <= cfg_data;
                            sincos_pkg::RegSpanNeeded: span_needed_reg <= cfg_data;
                            sincos_pkg::RegAmpFloor:   amp_floor_reg <= cfg_data;
                            sincos_pkg::RegAmpLowLim:  amp_low_limit_reg <= cfg_data;
                            sincos_pkg::RegRailMargin: rail_margin_reg <= cfg_data[14:0];
                            default: ;
                        endcase
                    end
                    if (s_valid) begin
                        if (s_command) begin
                            sin_lo_reg <= sin_hi_cap_reg; sin_hi_reg <= sin_lo_cap_reg;
                            cos_lo_reg <= cos_hi_cap_reg; cos_hi_reg <= cos_lo_cap_reg;
                            avg_reg <= '0; started_reg <= 1'b0;
                            low_run_reg <= '0; rail_run_reg <= '0;
                            o_angle_reg <= '0; o_aval_reg <= 1'b0; o_act_reg <= 1'b0;
                            o_af_reg <= 1'b0; o_rf_reg <= 1'b0;
                            state_reg <= ST_OUT;
                        end else begin
                            rs_reg <= s_sin_sample; rc_reg <= s_cos_sample;
                            cs_reg <= cs_c; cc_reg <= cc_c;
                            if (cs_c < sin_lo_reg) sin_lo_reg <= cs_c;
                            if (cs_c > sin_hi_reg) sin_hi_reg <= cs_c;
                            if (cc_c < cos_lo_reg) cos_lo_reg <= cc_c;
                            if (cc_c > cos_hi_reg) cos_hi_reg <= cc_c;
                            state_reg <= ST_BOUNDS;
                        end
                    end
                end
                ST_BOUNDS: begin
                    // spans and centered clamped values
                    sspan_reg <= (sin_hi_reg > sin_lo_reg) ? {1'b0, sin_hi_reg - sin_lo_reg} : '0;
                    cspan_reg <= (cos_hi_reg > cos_lo_reg) ? {1'b0, cos_hi_reg - cos_lo_reg} : '0;
                    ds_reg <= $signed({1'b0, cs_reg - sin_lo_reg, 1'b0})
                        - $signed({1'b0, (sin_hi_reg > sin_lo_reg) ? sin_hi_reg - sin_lo_reg : 16'd0});
                    dc_reg <= $signed({1'b0, cc_reg - cos_lo_reg, 1'b0})
                        - $signed({1'b0, (cos_hi_reg > cos_lo_reg) ? cos_hi_reg - cos_lo_reg : 16'd0});
                    mcnt_reg <= 2'd0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    valid_reg  <= (sspan_reg != 0) && (cspan_reg != 0);
                    active_reg <= (sspan_reg > {1'b0, span_needed_reg})
                               && (cspan_reg > {1'b0, span_needed_reg});
                    case (mcnt_reg)
                        2'd0: x_reg <= 38'(mul_p);
                        2'd1: y_reg <= 38'(mul_p);
                        2'd2: sq_reg <= mul_p[35:0];
                        default: sq_reg <= sq_reg + mul_p[35:0];
                    endcase
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3) state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    // half-turn pre-rotation, zero vector marked for a zero angle
                    step_reg <= '0;
                    if (x_reg == 0 && y_reg == 0) begin
                        phase_reg <= 32'hFFFF8000;
                    end else if (x_reg < 0) begin
                        x_reg <= -x_reg; y_reg <= -y_reg; phase_reg <= 32'h80000000;
                    end else begin
                        phase_reg <= '0;
                    end
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    if (phase_reg != 32'hFFFF8000 || x_reg != 0 || y_reg != 0) begin
                        if (y_reg >= 0) begin
                            x_reg <= x_reg + ys_c; y_reg <= y_reg - xs_c;
                            phase_reg <= phase_reg + sincos_pkg::atan_turn(step_reg);
                        end else begin
                            x_reg <= x_reg - ys_c; y_reg <= y_reg + xs_c;
                            phase_reg <= phase_reg - sincos_pkg::atan_turn(step_reg);
                        end
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(sincos_pkg::CordicSteps - 1)) state_reg <= ST_SQSUM;
                end
                ST_SQSUM: begin
                    o_angle_reg <= valid_reg ? 16'(({phase_reg} + 32'h8000) >> 16) : 16'd0;
                    rem_reg  <= {sq_reg, 16'd0} >> 2;
                    root_reg <= '0;
                    step_reg <= 5'd25;
                    state_reg <= active_reg ? ST_SQRT : ST_RUNS;
                end
                ST_SQRT: begin
                    if (rem_reg >= trial_c) begin
                        rem_reg  <= rem_reg - trial_c;
                        root_reg <= (root_reg >> 1) + bit_c;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0) state_reg <= ST_AVG;
                end
                ST_AVG: begin
                    if (!started_reg) begin
                        avg_reg <= mag_reg; started_reg <= 1'b1;
                    end else begin
                        avg_reg <= 25'($signed({2'b0, avg_reg}) + dstep_c);
                    end
                    state_reg <= ST_RUNS;
                end
                ST_RUNS: begin
                    o_aval_reg <= valid_reg;
                    o_act_reg  <= active_reg;
                    o_af_reg <= 1'b0; o_rf_reg <= 1'b0;
                    if (active_reg) begin
                        if ({avg_reg} < {1'b0, amp_floor_reg, 8'd0}) begin
                            if (low_inc_c >= amp_low_limit_reg) begin
                                o_af_reg <= 1'b1; low_run_reg <= '0;
                            end else begin
                                low_run_reg <= low_inc_c;
                            end
                        end else begin
                            low_run_reg <= '0;
                        end
                        if (at_rail_c) begin
                            if (rail_inc_c >= 16'(sincos_pkg::RailHits)) begin
                                o_rf_reg <= 1'b1; rail_run_reg <= '0;
                            end else begin
                                rail_run_reg <= rail_inc_c;
                            end
                        end else begin
                            rail_run_reg <= '0;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // root capture
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQRT && step_reg == 5'd0) begin
            mag_reg <= (rem_reg >= trial_c) ? 25'((root_reg >> 1) + bit_c)
                                            : 25'(root_reg >> 1);
        end
    end

endmodule
